/* rtl/core/xmrs_pkg.sv */
// Shared types and constants for the XOR-masked needle search.
// Used by the cell, the top level and the port checker; no dependencies.
package xmrs_pkg;

   localparam int BYTE_W       = 8;
   localparam int WORD_W       = 64;
   localparam int NEEDLE_WORDS = 4;
   localparam int NIDX_W       = 5;   // selects one of the 32 needle bytes
   localparam int NLEN_W       = 6;   // width of the needle length register
   localparam int CSR_ADDR_W   = 6;
   localparam int CSR_DATA_W   = 64;

   typedef logic [NEEDLE_WORDS-1:0][WORD_W-1:0] needle_type;

   // register map, eight bytes per register
   typedef enum logic [2:0] {
      REG_NEEDLE_0      = 3'd0,
      REG_NEEDLE_1      = 3'd1,
      REG_NEEDLE_2      = 3'd2,
      REG_NEEDLE_3      = 3'd3,
      REG_NEEDLE_LENGTH = 3'd4
   } reg_index_type;

   typedef enum logic [1:0] {
      STATUS_UNIQUE     = 2'd0,
      STATUS_NOT_FOUND  = 2'd1,
      STATUS_NOT_UNIQUE = 2'd2
   } status_type;

   // per-cell control from the top level
   typedef struct packed {
      logic shift;    // take the neighbor's byte
      logic in_use;   // cell lies inside the active needle length
   } cell_ctl_type;

   // needle byte idx, byte 0 in the low bits of word 0
   function automatic logic [BYTE_W-1:0] needle_byte(needle_type words,
                                                     logic [NIDX_W-1:0] idx);
      return words[idx[NIDX_W-1:3]][{idx[2:0], 3'b000} +: BYTE_W];
   endfunction

endpackage

/* rtl/core/xmrs_cell.sv */
// One window cell: holds a haystack byte and compares it against its needle byte.
// Depends on xmrs_pkg.
module xmrs_cell (
   input  logic                          clock,
   input  xmrs_pkg::cell_ctl_type        ctl,
   input  logic [xmrs_pkg::BYTE_W-1:0]   prev_byte,
   input  logic [xmrs_pkg::BYTE_W-1:0]   needle_val,
   input  logic [xmrs_pkg::BYTE_W-1:0]   mask,
   output logic [xmrs_pkg::BYTE_W-1:0]   byte_out,
   output logic [xmrs_pkg::BYTE_W-1:0]   diff,
   output logic                          cell_ok
);

   logic [xmrs_pkg::BYTE_W-1:0] byte_ff;
   logic [xmrs_pkg::BYTE_W-1:0] byte_in;

   // advance the window by one byte on each request
   always_comb begin
      byte_in = ctl.shift ? prev_byte : byte_ff;
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   // the mask this cell implies, and whether it agrees with the window mask
   assign byte_out = byte_ff;
   assign diff     = byte_ff ^ needle_val;
   assign cell_ok  = !ctl.in_use || (diff == mask);

endmodule

/* rtl/core/xor_mask_recovery_search.sv */
// A request marked last passes the window cells and the compare stage into the result register.
// Throughput: one request per cycle; a last request waits in the compare stage
// only while the previous result is still held on the result channel.
// The window is a row of MAX_NEEDLE byte cells with one compare stage behind it.
// Synchronous reset clears the search state (not window or result data); no clearing pass.
module xor_mask_recovery_search #(
   parameter int MAX_NEEDLE = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [xmrs_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [xmrs_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [xmrs_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   // haystack requests
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [7:0] data_byte
   input  logic                              req_tlast,   // final_byte
   // results
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [7:0]                        rsp_tdata,   // [7:0] found_mask
   output logic [1:0]                        rsp_tuser    // [1:0] search_status
);

   localparam int LEN_W  = $clog2(MAX_NEEDLE + 1);
   localparam int IDX_W  = $clog2(MAX_NEEDLE);
   localparam int NLEN_W = xmrs_pkg::NLEN_W;
   localparam int NIDX_W = xmrs_pkg::NIDX_W;

   // configuration registers
   xmrs_pkg::needle_type        needle_ff, needle_in;
   logic [NLEN_W-1:0]           nlen_ff, nlen_in;
   xmrs_pkg::reg_index_type     csr_idx;
   logic                        csr_write;

   // request and compare stages
   logic                        req_accept;
   logic                        s1_valid_ff, s1_valid_in;
   logic                        s1_final_ff, s1_final_in;
   logic                        restart_ff, restart_in;
   logic [LEN_W-1:0]            filled_ff, filled_in;
   logic [1:0]                  tally_ff, tally_in, tally_next;
   logic [7:0]                  first_mask_ff, first_mask_in, first_mask_next;
   logic                        b_go;
   logic                        hit;

   // result register
   logic                        rsp_valid_ff, rsp_valid_in;
   xmrs_pkg::status_type        rsp_status_ff, rsp_status_in;
   logic [7:0]                  rsp_mask_ff, rsp_mask_in;

   // window
   logic [LEN_W-1:0]            n_eff;
   logic [IDX_W-1:0]            last_idx;
   logic [7:0]                  mask;
   logic [7:0]                  cell_byte [MAX_NEEDLE];
   logic [7:0]                  cell_diff [MAX_NEEDLE];
   logic [MAX_NEEDLE-1:0]       cell_ok;

   // decode the configuration port
   assign csr_pready = 1'b1;
   assign csr_idx    = xmrs_pkg::reg_index_type'(csr_paddr[xmrs_pkg::CSR_ADDR_W-1:3]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      needle_in = needle_ff;
      nlen_in   = nlen_ff;
      if (csr_write) begin
         unique case (csr_idx)
            xmrs_pkg::REG_NEEDLE_0:      needle_in[0] = csr_pwdata;
            xmrs_pkg::REG_NEEDLE_1:      needle_in[1] = csr_pwdata;
            xmrs_pkg::REG_NEEDLE_2:      needle_in[2] = csr_pwdata;
            xmrs_pkg::REG_NEEDLE_3:      needle_in[3] = csr_pwdata;
            xmrs_pkg::REG_NEEDLE_LENGTH: nlen_in = csr_pwdata[NLEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         xmrs_pkg::REG_NEEDLE_0:      csr_prdata = needle_ff[0];
         xmrs_pkg::REG_NEEDLE_1:      csr_prdata = needle_ff[1];
         xmrs_pkg::REG_NEEDLE_2:      csr_prdata = needle_ff[2];
         xmrs_pkg::REG_NEEDLE_3:      csr_prdata = needle_ff[3];
         xmrs_pkg::REG_NEEDLE_LENGTH: csr_prdata = xmrs_pkg::CSR_DATA_W'(nlen_ff);
         default:                     csr_prdata = '0;
      endcase
   end

   // clamp the needle length to the window size
   assign n_eff    = (nlen_ff > NLEN_W'(MAX_NEEDLE)) ? LEN_W'(MAX_NEEDLE)
                                                      : LEN_W'(nlen_ff);
   assign last_idx = IDX_W'(n_eff - LEN_W'(1));

   // row of window cells, newest byte in cell 0
   for (genvar i = 0; i < MAX_NEEDLE; i++) begin : g_cell
      localparam logic [LEN_W-1:0] POS = LEN_W'(i);
      xmrs_pkg::cell_ctl_type ctl;
      logic [NIDX_W-1:0]      nidx;
      logic [7:0]             prev_byte;

      assign ctl.shift  = req_accept;
      assign ctl.in_use = POS < n_eff;
      assign nidx       = NIDX_W'(n_eff - LEN_W'(1) - POS);
      if (i == 0) begin : g_head
         assign prev_byte = req_tdata;
      end else begin : g_link
         assign prev_byte = cell_byte[i-1];
      end

      xmrs_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .prev_byte  (prev_byte),
         .needle_val (xmrs_pkg::needle_byte(needle_ff, nidx)),
         .mask       (mask),
         .byte_out   (cell_byte[i]),
         .diff       (cell_diff[i]),
         .cell_ok    (cell_ok[i])
      );
   end

   // the oldest byte of the window sets the mask
   assign mask = cell_diff[last_idx];

   // handshake: the compare stage holds only a last request facing a full result
   assign b_go       = s1_valid_ff && (!s1_final_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !(s1_valid_ff && !b_go);
   assign req_accept = req_tvalid && req_tready;

   // request stage: count bytes since the last final one
   always_comb begin
      s1_valid_in = b_go ? 1'b0 : s1_valid_ff;
      s1_final_in = s1_final_ff;
      restart_in  = restart_ff;
      filled_in   = filled_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
         s1_final_in = req_tlast;
         restart_in  = req_tlast;
         if (restart_ff) begin
            filled_in = LEN_W'(1);
         end else if (filled_ff != LEN_W'(MAX_NEEDLE)) begin
            filled_in = filled_ff + LEN_W'(1);
         end
      end
   end

   // compare stage: tally matches, build the result on a final byte
   assign hit = (n_eff != '0) && (filled_ff >= n_eff) && (&cell_ok);

   always_comb begin
      tally_next      = tally_ff;
      first_mask_next = first_mask_ff;
      if (hit) begin
         if (tally_ff == 2'd0) begin
            first_mask_next = mask;
         end
         if (tally_ff != 2'd2) begin
            tally_next = tally_ff + 2'd1;
         end
      end

      tally_in      = tally_ff;
      first_mask_in = first_mask_ff;
      rsp_valid_in  = rsp_tready ? 1'b0 : rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_mask_in   = rsp_mask_ff;
      if (b_go) begin
         tally_in      = s1_final_ff ? 2'd0 : tally_next;
         first_mask_in = s1_final_ff ? 8'd0 : first_mask_next;
         if (s1_final_ff) begin
            rsp_valid_in = 1'b1;
            rsp_mask_in  = 8'd0;
            if ((n_eff == '0) || (tally_next == 2'd2)) begin
               rsp_status_in = xmrs_pkg::STATUS_NOT_UNIQUE;
            end else if (tally_next == 2'd0) begin
               rsp_status_in = xmrs_pkg::STATUS_NOT_FOUND;
            end else begin
               rsp_status_in = xmrs_pkg::STATUS_UNIQUE;
               rsp_mask_in   = first_mask_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         needle_ff     <= '0;
         nlen_ff       <= '0;
         s1_valid_ff   <= 1'b0;
         s1_final_ff   <= 1'b0;
         restart_ff    <= 1'b0;
         filled_ff     <= '0;
         tally_ff      <= 2'd0;
         first_mask_ff <= 8'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         needle_ff     <= needle_in;
         nlen_ff       <= nlen_in;
         s1_valid_ff   <= s1_valid_in;
         s1_final_ff   <= s1_final_in;
         restart_ff    <= restart_in;
         filled_ff     <= filled_in;
         tally_ff      <= tally_in;
         first_mask_ff <= first_mask_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_mask_ff   <= rsp_mask_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_mask_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

/* rtl/core/xmrs_checker.sv */
// Port-level checks for the XOR-masked needle search, bound to the top level.
// Depends on xmrs_pkg and xor_mask_recovery_search.
module xmrs_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       req_tlast,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [1:0] rsp_tuser
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // only a unique match carries a mask
   a_mask_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != xmrs_pkg::STATUS_UNIQUE) |-> rsp_tdata == 8'd0)
      else $error("mask set without a unique match");

   // a fresh result traces back to an accepted last request
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready && req_tlast, 2))
      else $error("result without a last request");

   // requests stall only behind a held result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("request stalled with no result waiting");

endmodule

bind xor_mask_recovery_search xmrs_checker u_xmrs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

/* sim/tb.sv */
// Self-checking testbench for xor_mask_recovery_search: haystack streams against a
// running predictor of the masked needle search, with register readback.
// Depends on xmrs_pkg and the xor_mask_recovery_search RTL only.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_NEEDLE    = 32;
   localparam int ITEM_GOAL     = 1250;
   localparam int QUIET_AFTER   = 1050;
   localparam int PRESSURE_AT   = 400;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 4;
   localparam int CYCLE_LIMIT   = 100000;

   typedef struct packed {
      xmrs_pkg::status_type  status;
      logic [7:0]            mask;
   } search_result_type;

   typedef struct packed {
      bit                       cfg;
      xmrs_pkg::reg_index_type  reg_sel;
      logic [63:0]              value;
      logic [7:0]               data;
      bit                       last;
      bit                       typed;
      xmrs_pkg::status_type     status;
      logic [7:0]               mask;
   } plan_row_type;

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              csr_psel;
   logic                              csr_penable;
   logic                              csr_pwrite;
   logic [xmrs_pkg::CSR_ADDR_W-1:0]   csr_paddr;
   logic [xmrs_pkg::CSR_DATA_W-1:0]   csr_pwdata;
   logic [xmrs_pkg::CSR_DATA_W-1:0]   csr_prdata;
   logic                              csr_pready;
   logic                              req_tvalid;
   logic                              req_tready;
   logic [7:0]                        req_tdata;   // [7:0] data_byte
   logic                              req_tlast;   // final_byte
   logic                              rsp_tvalid;
   logic                              rsp_tready;
   logic [7:0]                        rsp_tdata;   // [7:0] found_mask
   logic [1:0]                        rsp_tuser;   // [1:0] search_status

   // predictor state: register mirror and search state
   logic [63:0]    needle_words [xmrs_pkg::NEEDLE_WORDS];
   logic [5:0]     needle_len;
   logic [7:0]     window [MAX_NEEDLE];
   int             filled;
   int             tally;
   logic [7:0]     first_hit_mask;

   search_result_type pending_results [$];
   plan_row_type      plan [$];

   int  errors          = 0;
   int  bytes_sent      = 0;
   int  results_checked = 0;
   int  settings_used   = 0;
   int  cycle_count     = 0;
   bit  gaps_on         = 1'b0;
   bit  stalls_on       = 1'b0;
   bit  hold_request    = 1'b0;

   xor_mask_recovery_search #(.MAX_NEEDLE(MAX_NEEDLE)) uut (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   always #4 clock = ~clock;

   // stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAILURE");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
      errors++;
   endtask

   function automatic int active_length();
      return (needle_len > MAX_NEEDLE) ? MAX_NEEDLE : int'(needle_len);
   endfunction

   function automatic logic [7:0] pattern_byte(input int j);
      return needle_words[j / 8][(j % 8) * 8 +: 8];
   endfunction

   function automatic void clear_search();
      foreach (window[i]) window[i] = 8'h00;
      filled         = 0;
      tally          = 0;
      first_hit_mask = 8'h00;
   endfunction

   // advance the window by one byte; on a final byte produce the verdict
   task automatic search_step(input logic [7:0] d, input bit last, output bit done,
                              output search_result_type res);
      int         n;
      logic [7:0] m;
      bit         hit;
      n = active_length();
      for (int i = MAX_NEEDLE - 1; i > 0; i--) window[i] = window[i - 1];
      window[0] = d;
      if (filled < MAX_NEEDLE) filled++;
      if (n > 0 && filled >= n) begin
         m   = window[n - 1] ^ pattern_byte(0);
         hit = 1'b1;
         for (int j = 0; j < n; j++)
            if ((window[n - 1 - j] ^ m) != pattern_byte(j)) hit = 1'b0;
         if (hit) begin
            if (tally == 0) first_hit_mask = m;
            if (tally < 2) tally++;
         end
      end
      done       = last;
      res.status = xmrs_pkg::STATUS_NOT_FOUND;
      res.mask   = 8'h00;
      if (last) begin
         if (n == 0 || tally >= 2) begin
            res.status = xmrs_pkg::STATUS_NOT_UNIQUE;
         end else if (tally == 1) begin
            res.status = xmrs_pkg::STATUS_UNIQUE;
            res.mask   = first_hit_mask;
         end
         clear_search();
      end
   endtask

   // offer one request; called and returning at a falling edge
   task automatic offer_byte(input logic [7:0] d, input bit last, input bit typed,
                             input search_result_type typed_res);
      bit                done;
      search_result_type res;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      search_step(d, last, done, res);
      if (done) pending_results.push_back(typed ? typed_res : res);
      bytes_sent++;
      @(negedge clock);
   endtask

   // drop valid and wait until every result is home and the pipeline is quiet
   task automatic settle_idle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // write one register, then read it back
   task automatic write_register(input xmrs_pkg::reg_index_type idx,
                                 input logic [63:0] value);
      logic [63:0] want;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= xmrs_pkg::CSR_ADDR_W'({idx, 3'b000});
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (idx == xmrs_pkg::REG_NEEDLE_LENGTH) needle_len = value[5:0];
      else needle_words[int'(idx)] = value;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      want = (idx == xmrs_pkg::REG_NEEDLE_LENGTH) ? {58'd0, value[5:0]} : value;
      if (csr_prdata !== want) report_mismatch("register readback", csr_prdata, want);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      // leave the bus idle before the next transfer
      @(negedge clock);
   endtask

   function automatic plan_row_type cfg_row(input xmrs_pkg::reg_index_type r,
                                            input logic [63:0] v);
      plan_row_type p;
      p         = '0;
      p.cfg     = 1'b1;
      p.reg_sel = r;
      p.value   = v;
      return p;
   endfunction

   function automatic plan_row_type byte_row(input logic [7:0] d, input bit last);
      plan_row_type p;
      p      = '0;
      p.data = d;
      p.last = last;
      return p;
   endfunction

   function automatic plan_row_type known_row(input logic [7:0] d,
                                              input xmrs_pkg::status_type s,
                                              input logic [7:0] m);
      plan_row_type p;
      p        = '0;
      p.data   = d;
      p.last   = 1'b1;
      p.typed  = 1'b1;
      p.status = s;
      p.mask   = m;
      return p;
   endfunction

   function automatic logic [7:0] pick_mask();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // new needle words and length, extremes included
   task automatic configure_phase();
      logic [63:0] w;
      int          pick;
      int          len;
      for (int k = 0; k < xmrs_pkg::NEEDLE_WORDS; k++) begin
         case ($urandom_range(0, 9))
            0:       w = '0;
            1:       w = '1;
            default: w = {$urandom, $urandom};
         endcase
         write_register(xmrs_pkg::reg_index_type'(k), w);
      end
      pick = $urandom_range(0, 19);
      if (pick == 0)       len = 0;
      else if (pick <= 8)  len = $urandom_range(1, 4);
      else if (pick <= 14) len = $urandom_range(5, 12);
      else if (pick <= 16) len = $urandom_range(13, 31);
      else if (pick <= 18) len = MAX_NEEDLE;
      else                 len = $urandom_range(MAX_NEEDLE + 1, 63);
      w      = {$urandom, $urandom};
      w[5:0] = 6'(len);
      write_register(xmrs_pkg::REG_NEEDLE_LENGTH, w);
      settings_used++;
   endtask

   // one haystack: mostly planted needles, some near misses, noise and short ones
   task automatic run_haystack();
      logic [7:0] hay [];
      logic [7:0] m;
      int         n;
      int         len;
      int         kind;
      int         plants;
      int         pos;
      n    = active_length();
      kind = $urandom_range(0, 9);
      if (n == 0) len = $urandom_range(1, 12);
      else if (kind == 9 && n > 1) len = $urandom_range(1, n - 1);
      else if (kind == 6 || kind == 7) len = n + $urandom_range(0, n + 8);
      else len = n + $urandom_range(0, 16);
      hay = new[len];
      foreach (hay[i]) hay[i] = 8'($urandom);
      plants = (kind <= 5) ? 1 : (kind <= 7) ? 2 : 0;
      if (n > 0 && len >= n) begin
         for (int p = 0; p < plants; p++) begin
            m   = pick_mask();
            pos = $urandom_range(0, len - n);
            for (int j = 0; j < n; j++) hay[pos + j] = pattern_byte(j) ^ m;
            // break the plant by one bit
            if (kind == 5)
               hay[pos + $urandom_range(0, n - 1)] ^= 8'(1 << $urandom_range(0, 7));
         end
      end
      for (int i = 0; i < len; i++) offer_byte(hay[i], i == len - 1, 1'b0, '0);
   endtask

   // result side: random stall bursts, one long hold-off on request
   initial begin
      int hold_n;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_tready   <= 1'b0;
            hold_request  = 1'b0;
            hold_n        = HOLD_CYCLES;
         end else if (stalls_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            hold_n      = $urandom_range(1, 5);
         end else begin
            rsp_tready <= 1'b1;
            hold_n      = $urandom_range(1, 8);
         end
         repeat (hold_n - 1) @(negedge clock);
      end
   end

   // check each accepted result against the oldest expectation
   always @(posedge clock) begin
      search_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with none expected", 64'({rsp_tuser, rsp_tdata}),
                            64'd0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_tuser !== want.status)
               report_mismatch("search_status", 64'(rsp_tuser), 64'(want.status));
            if (rsp_tdata !== want.mask)
               report_mismatch("found_mask", 64'(rsp_tdata), 64'(want.mask));
            results_checked++;
         end
      end
   end

   initial begin
      search_result_type known;
      bit                pressure_done;
      int                phase_count;
      reset       = 1'b1;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      rsp_tready  = 1'b0;
      pressure_done = 1'b0;
      foreach (needle_words[k]) needle_words[k] = '0;
      needle_len = '0;
      clear_search();

      // directed plan
      // zero-length needle out of reset, short and longer haystack
      plan.push_back(known_row(8'h00, xmrs_pkg::STATUS_NOT_UNIQUE, 8'h00));
      plan.push_back(byte_row(8'hFF, 1'b0));
      plan.push_back(known_row(8'h7E, xmrs_pkg::STATUS_NOT_UNIQUE, 8'h00));
      // single-byte needle: one byte is unique, two are not
      plan.push_back(cfg_row(xmrs_pkg::REG_NEEDLE_0, 64'hFFFF_FFFF_FFFF_FF3C));
      plan.push_back(cfg_row(xmrs_pkg::REG_NEEDLE_LENGTH, 64'd1));
      plan.push_back(known_row(8'hA5, xmrs_pkg::STATUS_UNIQUE, 8'h99));
      plan.push_back(byte_row(8'h01, 1'b0));
      plan.push_back(known_row(8'h02, xmrs_pkg::STATUS_NOT_UNIQUE, 8'h00));
      // three-byte needle: short haystack, mask all ones, mask zero
      plan.push_back(cfg_row(xmrs_pkg::REG_NEEDLE_0, 64'hFFFF_FFFF_FF30_2010));
      plan.push_back(cfg_row(xmrs_pkg::REG_NEEDLE_LENGTH, 64'd3));
      plan.push_back(byte_row(8'h10, 1'b0));
      plan.push_back(known_row(8'h20, xmrs_pkg::STATUS_NOT_FOUND, 8'h00));
      plan.push_back(byte_row(8'h00, 1'b0));
      plan.push_back(byte_row(8'hEF, 1'b0));
      plan.push_back(byte_row(8'hDF, 1'b0));
      plan.push_back(known_row(8'hCF, xmrs_pkg::STATUS_UNIQUE, 8'hFF));
      plan.push_back(byte_row(8'h10, 1'b0));
      plan.push_back(byte_row(8'h20, 1'b0));
      plan.push_back(known_row(8'h30, xmrs_pkg::STATUS_UNIQUE, 8'h00));
      // two matches under different masks
      plan.push_back(cfg_row(xmrs_pkg::REG_NEEDLE_0, 64'h0000_0000_0000_FF00));
      plan.push_back(cfg_row(xmrs_pkg::REG_NEEDLE_LENGTH, 64'd2));
      plan.push_back(byte_row(8'h12, 1'b0));
      plan.push_back(byte_row(8'hED, 1'b0));
      plan.push_back(byte_row(8'h34, 1'b0));
      plan.push_back(known_row(8'hCB, xmrs_pkg::STATUS_NOT_UNIQUE, 8'h00));
      // length above the maximum saturates; one byte is never a full window
      plan.push_back(cfg_row(xmrs_pkg::REG_NEEDLE_1, 64'hFFFF_FFFF_FFFF_FFFF));
      plan.push_back(cfg_row(xmrs_pkg::REG_NEEDLE_2, 64'h0000_0000_0000_0000));
      plan.push_back(cfg_row(xmrs_pkg::REG_NEEDLE_3, 64'hA5A5_5A5A_0F0F_F0F0));
      plan.push_back(cfg_row(xmrs_pkg::REG_NEEDLE_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF));
      plan.push_back(known_row(8'h55, xmrs_pkg::STATUS_NOT_FOUND, 8'h00));

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (plan[r]) begin
         if (plan[r].cfg) begin
            settle_idle();
            write_register(plan[r].reg_sel, plan[r].value);
         end else begin
            known.status = plan[r].status;
            known.mask   = plan[r].mask;
            offer_byte(plan[r].data, plan[r].last, plan[r].typed, known);
         end
      end

      // random phases, each under a fresh needle setting
      while (bytes_sent < ITEM_GOAL) begin
         settle_idle();
         configure_phase();
         if (bytes_sent >= QUIET_AFTER) begin
            gaps_on   = 1'b0;
            stalls_on = 1'b0;
         end else begin
            gaps_on   = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
         end
         phase_count = $urandom_range(1, 6);
         // long hold-off on the result side while dense requests keep coming
         if (!pressure_done && bytes_sent >= PRESSURE_AT) begin
            hold_request  = 1'b1;
            pressure_done = 1'b1;
            gaps_on       = 1'b0;
            phase_count   = 6;
         end
         repeat (phase_count) run_haystack();
      end

      // drain, with a bound
      req_tvalid <= 1'b0;
      for (int w = 0; w < 5000 && pending_results.size() != 0; w++) @(negedge clock);
      repeat (10) @(negedge clock);
      while (pending_results.size() != 0) begin
         report_mismatch("result never arrived", 64'd0, 64'(pending_results[0]));
         void'(pending_results.pop_front());
      end

      $display("run covered %0d haystack bytes and %0d search verdicts over %0d needle settings",
               bytes_sent, results_checked, settings_used);
      $display("results side held off once for %0d cycles; %0d mismatches",
               HOLD_CYCLES, errors);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
